// File: rtl/core/lmdw_pkg.sv
// lmdw_pkg: shared types, constants and helper function of the two-word bit sequencer
// used by the channel interfaces and by the top level; no dependencies
package lmdw_pkg;

    // word geometry
    localparam int unsigned WORD_BITS = 16;
    localparam int unsigned POS_W     = 4;   // bits to index one word bit
    localparam int unsigned STEP_W    = 5;   // step 0..31
    localparam int unsigned LFSR_W    = 32;

    localparam logic [LFSR_W-1:0] LFSR_SEED_DEFAULT = 32'habcdef12;

    // command codes
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_SINGLE     = 3'd2;
    localparam logic [2:0] CMD_FLIP_LONG  = 3'd3;
    localparam logic [2:0] CMD_FLIP_INV_A = 3'd4;
    localparam logic [2:0] CMD_FLIP_INV_B = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_SWITCH_A    = 3'd0;
    localparam logic [2:0] REG_SWITCH_B    = 3'd1;
    localparam logic [2:0] REG_WORD_LENGTH = 3'd2;
    localparam logic [2:0] REG_SINGLE_RUN  = 3'd3;
    localparam logic [2:0] REG_EXT_CLOCK   = 3'd4;
    localparam logic [2:0] REG_INV_A_INIT  = 3'd5;
    localparam logic [2:0] REG_INV_B_INIT  = 3'd6;
    localparam logic [2:0] REG_LONG_INIT   = 3'd7;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_GATE,
        ST_DIV_LEVEL,
        ST_DONE
    } t_state;

    // one result word
    typedef struct packed {
        logic                 level_a;
        logic                 level_b;
        logic                 gate_a;
        logic                 gate_b;
        logic                 first_bit;
        logic                 last_bit;
        logic [WORD_BITS-1:0] shown_word_a;
        logic [WORD_BITS-1:0] shown_word_b;
        logic [STEP_W-1:0]    step_index;
    } t_result;

    // fibonacci lfsr, taps 0 1 21 31, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
        logic fb;
        fb = cur[0] ^ cur[1] ^ cur[21] ^ cur[31];
        return {fb, cur[LFSR_W-1:1]};
    endfunction

endpackage

// File: rtl/core/lmdw_ifs.sv
// lmdw channel interfaces: input word, result word and configuration write channels
// depends on lmdw_pkg for field widths
interface lmdw_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    cmd;
    logic [lmdw_pkg::WORD_BITS-1:0] prn_choice_a;
    logic [lmdw_pkg::WORD_BITS-1:0] prn_choice_b;
    logic [lmdw_pkg::LFSR_W-1:0]   seed;

    modport source (output valid, cmd, prn_choice_a, prn_choice_b, seed, input ready);
    modport sink   (input valid, cmd, prn_choice_a, prn_choice_b, seed, output ready);
endinterface

interface lmdw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          level_a;
    logic                          level_b;
    logic                          gate_a;
    logic                          gate_b;
    logic                          first_bit;
    logic                          last_bit;
    logic [lmdw_pkg::WORD_BITS-1:0] shown_word_a;
    logic [lmdw_pkg::WORD_BITS-1:0] shown_word_b;
    logic [lmdw_pkg::STEP_W-1:0]   step_index;

    modport source (output valid, level_a, level_b, gate_a, gate_b, first_bit, last_bit,
                    shown_word_a, shown_word_b, step_index, input ready);
    modport sink   (input valid, level_a, level_b, gate_a, gate_b, first_bit, last_bit,
                    shown_word_a, shown_word_b, step_index, output ready);
endinterface

interface lmdw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [15:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/lfsr_mixed_dual_word_bit_sequencer.sv
// two-word lfsr / manual bit sequencer, top level
// depends on lmdw_pkg and the channel interfaces in lmdw_ifs.sv
//
// usage
//   i_item   : command words (tick, reset with seed, single cycle, flips of long
//              mode and of the two inversions) with the two lfsr choice masks
//   o_result : one result word per command word: levels, gates, first and last
//              bit pulses, both shown words and the step after the command
//   i_cfg    : register writes by index; always ready, write only while idle
// step division
//   a word passes the exec, gate division, level division and done states; the
//   quotients of the old and new step by the segment length are taken off by one
//   shared compare-and-subtract unit, one subtraction per cycle; a new command
//   word is taken only in the idle state, after the last result is written
// reset
//   synchronous, active low: configuration and control registers return to their
//   defaults, the lfsr to 0xabcdef12, step and single-cycle flags to zero
// stalls
//   the result sits in an output register; while it waits the next command word
//   is taken and worked on, and only its final write waits for the register
module lfsr_mixed_dual_word_bit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmdw_in_if.sink     i_item,
    lmdw_cfg_if.sink    i_cfg,
    lmdw_out_if.source  o_result
);

    localparam int unsigned WB = lmdw_pkg::WORD_BITS;
    localparam int unsigned SW = lmdw_pkg::STEP_W;
    localparam int unsigned PW = lmdw_pkg::POS_W;
    localparam int unsigned LW = lmdw_pkg::LFSR_W;

    // configuration registers
    logic [WB-1:0] r_switch_a;
    logic [WB-1:0] r_switch_b;
    logic [4:0]    r_word_length;
    logic          r_single_run;
    logic          r_ext_clock;
    logic          r_inv_a_init;
    logic          r_inv_b_init;
    logic          r_long_init;

    // sequencer state
    lmdw_pkg::t_state r_state, n_state;
    logic [LW-1:0] r_lfsr, n_lfsr;
    logic [SW-1:0] r_step, n_step;
    logic [WB-1:0] r_word_a, n_word_a;
    logic [WB-1:0] r_word_b, n_word_b;
    logic          r_single_active, n_single_active;
    logic          r_single_done, n_single_done;
    logic          r_inv_a, n_inv_a;
    logic          r_inv_b, n_inv_b;
    logic          r_long, n_long;
    logic          r_out_valid, n_out_valid;

    // per-word payload
    logic [2:0]    r_cmd, n_cmd;
    logic [WB-1:0] r_choice_a, n_choice_a;
    logic [WB-1:0] r_choice_b, n_choice_b;
    logic [LW-1:0] r_seed, n_seed;
    logic          r_play, n_play;
    logic          r_first, n_first;
    logic          r_last, n_last;
    logic          r_gate_a, n_gate_a;
    logic          r_gate_b, n_gate_b;
    logic          r_level_a, n_level_a;
    logic          r_level_b, n_level_b;
    logic [SW-1:0] r_rem, n_rem;
    logic          r_par, n_par;
    lmdw_pkg::t_result r_out, n_out;

    // segment and sequence length
    logic [4:0] seg_n;
    logic [5:0] seq_n;
    logic [WB-1:0] shown_a;
    logic [WB-1:0] shown_b;
    logic          bit_a;
    logic          bit_b;
    logic          rem_ge;

    assign seg_n = (r_word_length == 5'd0) ? 5'd1 :
                   (r_word_length > 5'(WB)) ? 5'(WB) : r_word_length;
    assign seq_n = r_long ? {seg_n, 1'b0} : {1'b0, seg_n};

    // shown words and the bit picked by the divider remainder
    assign shown_a = r_inv_a ? ~r_word_a : r_word_a;
    assign shown_b = r_inv_b ? ~r_word_b : r_word_b;
    assign bit_a   = (r_long && r_par) ? shown_b[r_rem[PW-1:0]] : shown_a[r_rem[PW-1:0]];
    assign bit_b   = (r_long && r_par) ? shown_a[r_rem[PW-1:0]] : shown_b[r_rem[PW-1:0]];
    assign rem_ge  = (r_rem >= seg_n);

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_a    <= '0;
            r_switch_b    <= '0;
            r_word_length <= 5'd16;
            r_single_run  <= 1'b0;
            r_ext_clock   <= 1'b0;
            r_inv_a_init  <= 1'b0;
            r_inv_b_init  <= 1'b0;
            r_long_init   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                lmdw_pkg::REG_SWITCH_A:    r_switch_a    <= i_cfg.data[WB-1:0];
                lmdw_pkg::REG_SWITCH_B:    r_switch_b    <= i_cfg.data[WB-1:0];
                lmdw_pkg::REG_WORD_LENGTH: r_word_length <= i_cfg.data[4:0];
                lmdw_pkg::REG_SINGLE_RUN:  r_single_run  <= i_cfg.data[0];
                lmdw_pkg::REG_EXT_CLOCK:   r_ext_clock   <= i_cfg.data[0];
                lmdw_pkg::REG_INV_A_INIT:  r_inv_a_init  <= i_cfg.data[0];
                lmdw_pkg::REG_INV_B_INIT:  r_inv_b_init  <= i_cfg.data[0];
                lmdw_pkg::REG_LONG_INIT:   r_long_init   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // handshakes and result port
    assign i_item.ready          = (r_state == lmdw_pkg::ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.level_a      = r_out.level_a;
    assign o_result.level_b      = r_out.level_b;
    assign o_result.gate_a       = r_out.gate_a;
    assign o_result.gate_b       = r_out.gate_b;
    assign o_result.first_bit    = r_out.first_bit;
    assign o_result.last_bit     = r_out.last_bit;
    assign o_result.shown_word_a = r_out.shown_word_a;
    assign o_result.shown_word_b = r_out.shown_word_b;
    assign o_result.step_index   = r_out.step_index;

    // next state and datapath
    always_comb begin
        logic          run;
        logic          adv;
        logic [5:0]    step_inc;

        run             = 1'b0;
        adv             = 1'b0;
        step_inc        = '0;
        n_state         = r_state;
        n_lfsr          = r_lfsr;
        n_step          = r_step;
        n_word_a        = r_word_a;
        n_word_b        = r_word_b;
        n_single_active = r_single_active;
        n_single_done   = r_single_done;
        n_inv_a         = r_inv_a;
        n_inv_b         = r_inv_b;
        n_long          = r_long;
        n_cmd           = r_cmd;
        n_choice_a      = r_choice_a;
        n_choice_b      = r_choice_b;
        n_seed          = r_seed;
        n_play          = r_play;
        n_first         = r_first;
        n_last          = r_last;
        n_gate_a        = r_gate_a;
        n_gate_b        = r_gate_b;
        n_level_a       = r_level_a;
        n_level_b       = r_level_b;
        n_rem           = r_rem;
        n_par           = r_par;
        n_out           = r_out;
        n_out_valid     = r_out_valid;

        // result taken by the receiver
        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lmdw_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_cmd      = i_item.cmd;
                    n_choice_a = i_item.prn_choice_a;
                    n_choice_b = i_item.prn_choice_b;
                    n_seed     = i_item.seed;
                    n_state    = lmdw_pkg::ST_EXEC;
                end
            end

            lmdw_pkg::ST_EXEC: begin
                n_first = 1'b0;
                n_last  = 1'b0;
                // command effects
                case (r_cmd)
                    lmdw_pkg::CMD_RESET: begin
                        n_step          = '0;
                        n_single_active = 1'b0;
                        n_single_done   = 1'b0;
                        n_lfsr          = (r_seed != '0) ? r_seed
                                                         : lmdw_pkg::LFSR_SEED_DEFAULT;
                        n_word_a        = r_switch_a;
                        n_word_b        = r_switch_b;
                    end
                    lmdw_pkg::CMD_SINGLE: begin
                        n_step          = '0;
                        n_single_active = 1'b1;
                        n_single_done   = 1'b0;
                        if (r_ext_clock) begin
                            adv     = 1'b1;
                            n_first = 1'b1;
                            if (seq_n == 6'd1) begin
                                n_last        = 1'b1;
                                n_single_done = 1'b1;
                            end
                        end
                    end
                    lmdw_pkg::CMD_FLIP_LONG:  n_long  = !r_long;
                    lmdw_pkg::CMD_FLIP_INV_A: n_inv_a = !r_inv_a;
                    lmdw_pkg::CMD_FLIP_INV_B: n_inv_b = !r_inv_b;
                    default: ;
                endcase

                // end of a finished single cycle, run decision
                if (n_single_active) begin
                    run = !n_single_done;
                    if (n_single_done) begin
                        n_single_active = 1'b0;
                    end
                end else begin
                    run = !r_single_run;
                end
                n_play = (r_cmd == lmdw_pkg::CMD_TICK) && run;

                // lfsr advance and word build
                if (adv || n_play) begin
                    n_lfsr   = lmdw_pkg::lfsr_next(r_lfsr);
                    n_word_a = (n_lfsr[WB-1:0] & r_choice_a) | (r_switch_a & ~r_choice_a);
                    n_word_b = (n_lfsr[16 +: WB] & r_choice_b) | (r_switch_b & ~r_choice_b);
                end

                // played step: pulses and step advance
                if (n_play) begin
                    n_first = (r_step == '0);
                    if ({1'b0, r_step} == seq_n - 6'd1) begin
                        n_last = 1'b1;
                        if (n_single_active) begin
                            n_single_done = 1'b1;
                        end
                    end
                    if (!((r_single_run || n_single_active) && n_single_done)) begin
                        step_inc = {1'b0, r_step} + 6'd1;
                        n_step   = (step_inc >= seq_n) ? '0 : step_inc[SW-1:0];
                    end
                end

                // divider starts on the step just played
                n_rem   = r_step;
                n_par   = 1'b0;
                n_state = lmdw_pkg::ST_DIV_GATE;
            end

            lmdw_pkg::ST_DIV_GATE: begin
                if (rem_ge) begin
                    n_rem = r_rem - seg_n;
                    n_par = !r_par;
                end else begin
                    n_gate_a = r_play & bit_a;
                    n_gate_b = r_play & bit_b;
                    n_rem    = r_step;
                    n_par    = 1'b0;
                    n_state  = lmdw_pkg::ST_DIV_LEVEL;
                end
            end

            lmdw_pkg::ST_DIV_LEVEL: begin
                if (rem_ge) begin
                    n_rem = r_rem - seg_n;
                    n_par = !r_par;
                end else begin
                    n_level_a = bit_a;
                    n_level_b = bit_b;
                    n_state   = lmdw_pkg::ST_DONE;
                end
            end

            lmdw_pkg::ST_DONE: begin
                // load the output register once it is free
                if (!r_out_valid || o_result.ready) begin
                    n_out.level_a      = r_level_a;
                    n_out.level_b      = r_level_b;
                    n_out.gate_a       = r_gate_a;
                    n_out.gate_b       = r_gate_b;
                    n_out.first_bit    = r_first;
                    n_out.last_bit     = r_last;
                    n_out.shown_word_a = shown_a;
                    n_out.shown_word_b = shown_b;
                    n_out.step_index   = r_step;
                    n_out_valid        = 1'b1;
                    n_state            = lmdw_pkg::ST_IDLE;
                end
            end

            default: n_state = lmdw_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= lmdw_pkg::ST_IDLE;
            r_lfsr          <= lmdw_pkg::LFSR_SEED_DEFAULT;
            r_step          <= '0;
            r_word_a        <= '0;
            r_word_b        <= '0;
            r_single_active <= 1'b0;
            r_single_done   <= 1'b0;
            r_inv_a         <= 1'b0;
            r_inv_b         <= 1'b0;
            r_long          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_lfsr          <= n_lfsr;
            r_step          <= n_step;
            r_word_a        <= n_word_a;
            r_word_b        <= n_word_b;
            r_single_active <= n_single_active;
            r_single_done   <= n_single_done;
            r_inv_a         <= n_inv_a;
            r_inv_b         <= n_inv_b;
            r_long          <= n_long;
            r_out_valid     <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_choice_a <= n_choice_a;
        r_choice_b <= n_choice_b;
        r_seed     <= n_seed;
        r_play     <= n_play;
        r_first    <= n_first;
        r_last     <= n_last;
        r_gate_a   <= n_gate_a;
        r_gate_b   <= n_gate_b;
        r_level_a  <= n_level_a;
        r_level_b  <= n_level_b;
        r_rem      <= n_rem;
        r_par      <= n_par;
        r_out      <= n_out;
    end

endmodule
